### sv/fhl_pkg.sv
package fhl_pkg;

   // default strip length
   localparam int CELLS_DEFAULT = 156;

   // field widths
   localparam int RAND_W  = 16;
   localparam int HEAT_W  = 8;
   localparam int ROLL_W  = 8;
   localparam int SPOS_W  = 3;
   localparam int CFG_W   = 8;
   localparam int INDEX_W = 8;
   localparam int COLOR_W = 8;
   localparam int REQ_W   = 40;
   localparam int RSP_W   = 32;

   // cooldown range is at most 255*10/8+2 = 320 for an 8-cell strip
   localparam int RANGE_W = 9;
   localparam int STEP_W  = 4;
   localparam int COOLING_SCALE = 10;
   localparam int RANGE_BASE    = 2;
   localparam int COOL_LEVELS   = 256;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_COOLING  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPARKING = 1'd1;

   localparam logic [CFG_W-1:0] COOLING_RESET  = 8'd55;
   localparam logic [CFG_W-1:0] SPARKING_RESET = 8'd120;

   // colour ramp thresholds on the scaled heat
   localparam logic [7:0] RAMP_HIGH = 8'h80;
   localparam logic [7:0] RAMP_MID  = 8'h40;
   localparam logic [7:0] FULL      = 8'd255;

   // divide by three as multiply by 683 / 2048, exact for sums up to 765
   localparam int SUM_W       = 10;
   localparam int THIRD_MUL   = 683;
   localparam int THIRD_SHIFT = 11;
   localparam int PROD_W      = 21;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_EMIT
   } fhl_state_type;

   // heat scaled to 0..191 with rounding
   typedef logic [7:0] scale_lut_type [256];

   function automatic scale_lut_type build_scale_lut();
      scale_lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = 8'((i * 191 + 127) / 255);
      end
      return lut;
   endfunction

   localparam scale_lut_type SCALE_LUT = build_scale_lut();

endpackage

### sv/fhl_ram.sv
module fhl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 156
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### sv/fire_heat_led_effect.sv
// one word in, one pixel out; a new word is taken only after the pixel of the last
// one is registered; each word runs the 16-step restoring remainder loop on its random
// word, then the cell update, then the pixel emit, which waits while the output stalls
// reset is synchronous and active high; heat reads as zero through the
// first frame by a fill mark, so there is no clearing pass
module fire_heat_led_effect #(
   parameter int CELLS = fhl_pkg::CELLS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // configuration writes
   input  logic                           csr_we,
   input  logic [fhl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fhl_pkg::CFG_W-1:0]      csr_wdata,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // cooldown_rand[15:0], spark_roll[23:16], spark_cell[26:24], spark_heat[34:27]
   input  logic [fhl_pkg::REQ_W-1:0]      req_tdata,
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pixel_index[7:0], red[15:8], green[23:16], blue[31:24]
   output logic [fhl_pkg::RSP_W-1:0]      rsp_tdata,
   // frame_last
   output logic                           rsp_tlast
);

   import fhl_pkg::*;

   localparam int CELL_W = $clog2(CELLS);

   fhl_state_type state_ff, state_in;

   logic [CFG_W-1:0]   cooling_ff, sparking_ff;
   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic               filled_ff, filled_in;
   logic [HEAT_W-1:0]  back_one_ff, back_one_in;
   logic [HEAT_W-1:0]  back_two_ff, back_two_in;
   logic               armed_ff, armed_in;
   logic [SPOS_W-1:0]  spos_ff, spos_in;
   logic [HEAT_W-1:0]  samount_ff, samount_in;
   logic [RAND_W-1:0]  rand_ff, rand_in;
   logic [RANGE_W-1:0] range_ff, range_in;
   logic [RANGE_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [HEAT_W-1:0]  heat_ff, heat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               slot_free;
   logic [RANGE_W-1:0] range_lut [COOL_LEVELS];
   logic [RANGE_W:0]   trial;
   logic               trial_fits;
   logic [HEAT_W-1:0]  ram_rd_data;
   logic [HEAT_W-1:0]  old_heat;
   logic [HEAT_W-1:0]  cooled;
   logic [SUM_W-1:0]   drift_sum;
   logic [PROD_W-1:0]  drift_prod;
   logic [HEAT_W-1:0]  drift;
   logic [HEAT_W-1:0]  diffused;
   logic               ram_we;
   logic [7:0]         scaled;
   logic [COLOR_W-1:0] ramp;
   logic [COLOR_W-1:0] red, green, blue;

   // cooldown range per cooling level, built at elaboration
   for (genvar c = 0; c < COOL_LEVELS; c++) begin : g_range
      localparam int RANGE_VAL = (c * COOLING_SCALE) / CELLS + RANGE_BASE;
      assign range_lut[c] = RANGE_W'(RANGE_VAL);
   end

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // shared compare and subtract: one remainder bit a step
   assign trial      = {rem_ff, rand_ff[RAND_W-1]};
   assign trial_fits = trial >= {1'b0, range_ff};

   // cooled heat of the current cell, saturating at zero
   assign old_heat = filled_ff ? ram_rd_data : '0;
   assign cooled   = ({1'b0, rem_ff} > (RANGE_W + 1)'(old_heat)) ? '0
                   : HEAT_W'(old_heat - rem_ff[HEAT_W-1:0]);

   // upward drift from the two cells below
   assign drift_sum  = SUM_W'(back_one_ff) + SUM_W'({back_two_ff, 1'b0});
   assign drift_prod = PROD_W'(drift_sum) * PROD_W'(THIRD_MUL);
   assign drift      = HEAT_W'(drift_prod >> THIRD_SHIFT);
   assign diffused   = (cell_ff >= CELL_W'(2)) ? drift : cooled;

   // colour ramp
   always_comb begin
      scaled = SCALE_LUT[heat_ff];
      ramp   = {scaled[5:0], 2'b00};
      if (scaled > RAMP_HIGH) begin
         red = FULL; green = FULL; blue = ramp;
      end else if (scaled > RAMP_MID) begin
         red = FULL; green = ramp; blue = '0;
      end else begin
         red = ramp; green = '0; blue = '0;
      end
   end

   // sequencer: next state and datapath next values
   always_comb begin
      state_in     = state_ff;
      cell_in      = cell_ff;
      filled_in    = filled_ff;
      back_one_in  = back_one_ff;
      back_two_in  = back_two_ff;
      armed_in     = armed_ff;
      spos_in      = spos_ff;
      samount_in   = samount_ff;
      rand_in      = rand_ff;
      range_in     = range_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      heat_in      = heat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rand_in  = req_tdata[15:0];
               range_in = range_lut[cooling_ff];
               rem_in   = '0;
               step_in  = '1;
               if (cell_ff == '0) begin
                  armed_in   = req_tdata[23:16] < sparking_ff;
                  spos_in    = req_tdata[26:24];
                  samount_in = req_tdata[34:27];
               end
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = trial_fits ? RANGE_W'(trial - {1'b0, range_ff})
                                 : trial[RANGE_W-1:0];
            rand_in = {rand_ff[RAND_W-2:0], 1'b0};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // spark lands after diffusion; the cooled value feeds upward
            heat_in = (armed_ff && cell_ff == CELL_W'(spos_ff))
                    ? HEAT_W'(diffused + samount_ff) : diffused;
            ram_we      = 1'b1;
            back_two_in = back_one_ff;
            back_one_in = cooled;
            state_in    = ST_UPDATE == state_ff ? ST_EMIT : state_ff;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {blue, green, red, INDEX_W'(cell_ff)};
               rsp_last_in  = cell_ff == CELL_W'(CELLS - 1);
               if (cell_ff == CELL_W'(CELLS - 1)) begin
                  cell_in   = '0;
                  filled_in = 1'b1;
               end else begin
                  cell_in = cell_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cooling_ff   <= COOLING_RESET;
         sparking_ff  <= SPARKING_RESET;
         cell_ff      <= '0;
         filled_ff    <= 1'b0;
         back_one_ff  <= '0;
         back_two_ff  <= '0;
         armed_ff     <= 1'b0;
         spos_ff      <= '0;
         samount_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_COOLING) begin
            cooling_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_SPARKING) begin
            sparking_ff <= csr_wdata;
         end
         cell_ff      <= cell_in;
         filled_ff    <= filled_in;
         back_one_ff  <= back_one_in;
         back_two_ff  <= back_two_in;
         armed_ff     <= armed_in;
         spos_ff      <= spos_in;
         samount_ff   <= samount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rand_ff     <= rand_in;
      range_ff    <= range_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      heat_ff     <= heat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // heat store, read on accept, written back after update
   fhl_ram #(
      .WIDTH (HEAT_W),
      .DEPTH (CELLS)
   ) u_heat_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cell_ff),
      .wr_data (heat_in),
      .rd_en   (accept),
      .rd_addr (cell_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_rem_below_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_UPDATE) |-> rem_ff < range_ff)
      else $error("remainder not below cooldown range");

   a_range_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> range_ff >= RANGE_W'(RANGE_BASE))
      else $error("cooldown range below two");

   a_cell_bound: assert property (@(posedge clock) disable iff (reset)
      cell_ff <= CELL_W'(CELLS - 1))
      else $error("cell counter out of range");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIVIDE && !req_tready)
      else $error("accepted word did not start the remainder loop");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[INDEX_W-1:0] == INDEX_W'(CELLS - 1))
      else $error("frame end flag on wrong pixel");

endmodule
